// ===== src/particle_code_charge_macros.svh =====
// Assertion macros shared by the particle code charge block.
`ifndef PARTICLE_CODE_CHARGE_MACROS_SVH
`define PARTICLE_CODE_CHARGE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define PCC_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define PCC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== src/pcc_pkg.sv =====
// Types, constants and the charge lookup shared by the particle code charge block.
package pcc_pkg;

	// Magnitude window that the digit stages split; larger codes are out of range
	localparam int MAG_W = 24;
	localparam int QUOT_W = MAG_W - 12;

	// Range limit and the divisor of the last quotient
	localparam int LIMIT_DIGITS = 10000000;
	localparam int DIGIT_BLOCK = 10000;
	localparam int HUNDRED = 100;

	// Reciprocal of ten for the multiply-and-shift divide
	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
	localparam int RECIP10_SHIFT = 35;

	// Full codes that override the fundamental table
	localparam logic [MAG_W-1:0] EXC_ZERO_A = MAG_W'(1000017);
	localparam logic [MAG_W-1:0] EXC_ZERO_B = MAG_W'(1000018);
	localparam logic [MAG_W-1:0] EXC_ZERO_C = MAG_W'(1000034);
	localparam logic [MAG_W-1:0] EXC_ZERO_D = MAG_W'(1000052);
	localparam logic [MAG_W-1:0] EXC_ZERO_E = MAG_W'(1000053);
	localparam logic [MAG_W-1:0] EXC_ZERO_F = MAG_W'(1000054);
	localparam logic [MAG_W-1:0] EXC_SIX_A = MAG_W'(5100061);
	localparam logic [MAG_W-1:0] EXC_SIX_B = MAG_W'(5100062);

	// Per-item flags that travel beside the digits
	typedef struct packed {
		logic neg;
		logic hi_nz;
		logic exc_zero;
		logic exc_six;
		logic is_hundred;
	} flags_t;

	// Decimal digits of the magnitude, units first
	typedef struct packed {
		logic [3:0] dj;
		logic [3:0] dq3;
		logic [3:0] dq2;
		logic [3:0] dq1;
	} digits_t;

	// Three times the charge of fundamental code idx (1 to 100); zero elsewhere
	function automatic logic signed [3:0] charge_lookup(input logic [6:0] idx);
		logic signed [3:0] q;
		q = 4'sd0;
		case (idx)
			7'd1, 7'd3, 7'd5, 7'd7, 7'd42: q = -4'sd1;
			7'd2, 7'd4, 7'd6, 7'd8: q = 4'sd2;
			7'd11, 7'd13, 7'd15, 7'd17: q = -4'sd3;
			7'd24, 7'd34, 7'd37, 7'd53: q = 4'sd3;
			7'd52, 7'd54: q = 4'sd6;
			default: q = 4'sd0;
		endcase
		return q;
	endfunction

endpackage

// ===== src/particle_code_charge.sv =====
// Top level of the particle code charge block: six-stage pipeline with handshake.
// Throughput: one request per cycle while the output is not stalled; the four divide-by-ten
// multipliers, one per stage, set the stage depth.
// Stages fill bubbles while the output stalls; a full pipeline holds its requests.
// Reset (arst_n low, asynchronous) empties every stage; no result is pending after it.
module particle_code_charge import pcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] particle_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // [3:0] charge_times_three, [7:4] zero
);

	`include "particle_code_charge_macros.svh"

	localparam int W1 = MAG_W;
	localparam int W2 = W1 - 3;
	localparam int W3 = W2 - 3;
	localparam int W4 = W3 - 3;
	localparam int QW = W4 - 3;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	logic             neg_s1, hi_nz_s1;
	logic [MAG_W-1:0] mag_s1;
	logic [W2-1:0]    quot_s2;
	logic [W3-1:0]    quot_s3;
	logic [W4-1:0]    quot_s4;
	logic [QW-1:0]    quot_s5;
	logic [3:0]       dj_s2, dq3_s3, dq2_s4, dq1_s5;
	logic [3:0]       dj_s3, dj_s4, dj_s5, dq3_s4, dq3_s5, dq2_s5;
	flags_t           flags_s2, flags_s3, flags_s4, flags_s5;
	digits_t          digits_s5;
	logic             exc_zero, exc_six, is_hundred;
	logic signed [3:0] charge_s6;

	// Advance a stage when it is empty or the next one advances
	assign rdy_s6   = !v_s6 || m_tready;
	assign rdy_s5   = !v_s5 || rdy_s6;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;
	assign m_tvalid = v_s6;
	assign m_tdata  = {4'b0000, charge_s6};

	// Move valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: sign and magnitude
	pcc_front u_front (
		.clk      (clk),
		.load     (rdy_s1),
		.code     (s_tdata),
		.neg_s1   (neg_s1),
		.hi_nz_s1 (hi_nz_s1),
		.mag_s1   (mag_s1)
	);

	// Stages 2 to 5: peel one decimal digit each
	pcc_digit #(.W(W1)) u_digit_s2 (
		.clk (clk), .load (rdy_s2), .x (mag_s1), .quot_q (quot_s2), .digit_q (dj_s2)
	);
	pcc_digit #(.W(W2)) u_digit_s3 (
		.clk (clk), .load (rdy_s3), .x (quot_s2), .quot_q (quot_s3), .digit_q (dq3_s3)
	);
	pcc_digit #(.W(W3)) u_digit_s4 (
		.clk (clk), .load (rdy_s4), .x (quot_s3), .quot_q (quot_s4), .digit_q (dq2_s4)
	);
	pcc_digit #(.W(W4)) u_digit_s5 (
		.clk (clk), .load (rdy_s5), .x (quot_s4), .quot_q (quot_s5), .digit_q (dq1_s5)
	);

	// Match the override codes beside the first digit stage
	assign exc_zero = (mag_s1 == EXC_ZERO_A) || (mag_s1 == EXC_ZERO_B)
		|| (mag_s1 == EXC_ZERO_C) || (mag_s1 == EXC_ZERO_D)
		|| (mag_s1 == EXC_ZERO_E) || (mag_s1 == EXC_ZERO_F);
	assign exc_six    = (mag_s1 == EXC_SIX_A) || (mag_s1 == EXC_SIX_B);
	assign is_hundred = (mag_s1 == MAG_W'(HUNDRED));

	// Carry flags and finished digits down the pipeline
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			flags_s2 <= '{neg: neg_s1, hi_nz: hi_nz_s1, exc_zero: exc_zero,
				exc_six: exc_six, is_hundred: is_hundred};
		end
		if (rdy_s3) begin
			flags_s3 <= flags_s2;
			dj_s3    <= dj_s2;
		end
		if (rdy_s4) begin
			flags_s4 <= flags_s3;
			dj_s4    <= dj_s3;
			dq3_s4   <= dq3_s3;
		end
		if (rdy_s5) begin
			flags_s5 <= flags_s4;
			dj_s5    <= dj_s4;
			dq3_s5   <= dq3_s4;
			dq2_s5   <= dq2_s4;
		end
	end

	assign digits_s5 = '{dj: dj_s5, dq3: dq3_s5, dq2: dq2_s5, dq1: dq1_s5};

	// Stage 6: rule selection and sign
	pcc_rule #(.Q_W(QW)) u_rule (
		.clk       (clk),
		.load      (rdy_s6),
		.flags     (flags_s5),
		.digits    (digits_s5),
		.quot      (quot_s5),
		.charge_s6 (charge_s6)
	);

	// A shown result stays within plus or minus six with a zero pad
	`PCC_ASSERT(a_charge_range, !m_tvalid || ((m_tdata[3:0] != 4'h7) && (m_tdata[3:0] != 4'h8) && (m_tdata[3:0] != 4'h9) && (m_tdata[7:4] == 4'h0)), "charge out of range")
	// A full pipeline under output stall takes no request
	`PCC_ASSERT(a_full_stall, !(v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && !m_tready) || !s_tready, "request taken into a full pipeline")
	// A magnitude beyond the window of the digit stages yields zero
	`PCC_ASSERT_NEXT(a_long_zero, v_s5 && rdy_s6 && flags_s5.hi_nz, m_tvalid && (m_tdata[3:0] == 4'h0), "out-of-range code gave nonzero charge")

endmodule

// ===== src/pcc_front.sv =====
// Input stage: sign and magnitude of the particle code.
module pcc_front import pcc_pkg::*; (
	input  logic             clk,
	input  logic             load,
	input  logic [31:0]      code,
	output logic             neg_s1,
	output logic             hi_nz_s1,
	output logic [MAG_W-1:0] mag_s1
);

	logic [31:0] mag;

	// Take the magnitude; the most negative pattern stays 2^31 and reads out of range
	assign mag = code[31] ? (32'd0 - code) : code;

	// Hold sign, high-part flag and low magnitude
	always_ff @(posedge clk) begin
		if (load) begin
			neg_s1   <= code[31];
			hi_nz_s1 <= (mag[31:MAG_W] != '0);
			mag_s1   <= mag[MAG_W-1:0];
		end
	end

endmodule

// ===== src/pcc_digit.sv =====
// One digit stage: quotient and remainder of a value divided by ten.
module pcc_digit import pcc_pkg::*; #(
	parameter int W = MAG_W
) (
	input  logic         clk,
	input  logic         load,
	input  logic [W-1:0] x,
	output logic [W-4:0] quot_q,
	output logic [3:0]   digit_q
);

	logic [W+31:0] prod;
	logic [W-4:0]  quot;
	logic [W-1:0]  times_ten;
	logic [W-1:0]  rem;

	// Divide by ten through the reciprocal, then take the remainder
	assign prod      = {32'd0, x} * {{W{1'b0}}, RECIP10};
	assign quot      = prod[W+31:RECIP10_SHIFT];
	assign times_ten = {quot, 3'b000} + {2'b00, quot, 1'b0};
	assign rem       = x - times_ten;

	// Hold quotient and digit
	always_ff @(posedge clk) begin
		if (load) begin
			quot_q  <= quot;
			digit_q <= rem[3:0];
		end
	end

endmodule

// ===== src/pcc_rule.sv =====
// Output stage: gives zero out of range, else picks the table, meson, diquark or baryon rule, and applies the sign.
module pcc_rule import pcc_pkg::*; #(
	parameter int Q_W = QUOT_W
) (
	input  logic              clk,
	input  logic              load,
	input  flags_t            flags,
	input  digits_t           digits,
	input  logic [Q_W-1:0]    quot,
	output logic signed [3:0] charge_s6
);

	localparam logic [Q_W-1:0] QUOT_LIMIT = Q_W'(LIMIT_DIGITS / DIGIT_BLOCK);

	logic              too_long;
	logic              table_hit;
	logic [6:0]        low_code;
	logic signed [3:0] t1, t2, t3;
	logic signed [3:0] mag_charge;

	// Low two digits as the fundamental index
	assign low_code = {digits.dq3, 3'b000} + {2'b00, digits.dq3, 1'b0} + {3'b000, digits.dj};
	assign too_long = flags.hi_nz || (quot >= QUOT_LIMIT);
	assign table_hit = ((digits.dq2 == 4'd0) && (digits.dq1 == 4'd0) && (low_code != 7'd0))
		|| flags.is_hundred;

	// Quark digit charges; digit zero reads zero
	assign t1 = charge_lookup({3'b000, digits.dq1});
	assign t2 = charge_lookup({3'b000, digits.dq2});
	assign t3 = charge_lookup({3'b000, digits.dq3});

	// Select the rule for the magnitude
	always_comb begin
		mag_charge = 4'sd0;
		if (too_long) begin
			mag_charge = 4'sd0;
		end else if (table_hit) begin
			if (flags.exc_zero) begin
				mag_charge = 4'sd0;
			end else if (flags.exc_six) begin
				mag_charge = 4'sd6;
			end else begin
				mag_charge = charge_lookup(low_code);
			end
		end else if (digits.dj == 4'd0) begin
			mag_charge = 4'sd0;
		end else if (digits.dq1 == 4'd0) begin
			if ((digits.dq2 == 4'd3) || (digits.dq2 == 4'd5)) begin
				mag_charge = t3 - t2;
			end else begin
				mag_charge = t2 - t3;
			end
		end else if (digits.dq3 == 4'd0) begin
			mag_charge = t2 + t1;
		end else begin
			mag_charge = t3 + t2 + t1;
		end
	end

	// Hold the signed result
	always_ff @(posedge clk) begin
		if (load) begin
			charge_s6 <= flags.neg ? -mag_charge : mag_charge;
		end
	end

endmodule
